// ----- sv/smm_pkg.sv -----
// Shared types and constants for the scrolling matrix marquee.
// Holds the beat structs, operation and source codes, and register indexes.
// No dependencies.
package smm_pkg;

	// Glyph geometry and user glyph store size
	localparam int GLYPH_COLUMNS  = 5;
	localparam int SPACED_COLUMNS = GLYPH_COLUMNS + 1;
	localparam int USER_CODES     = 16;
	localparam int USER_BYTES     = USER_CODES * GLYPH_COLUMNS;
	localparam int USER_AW        = $clog2(USER_BYTES);
	localparam int MAX_SENTENCE_DEF = 128;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 8;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_CHAR  = 2'd1,
		OP_GLYPH = 2'd2,
		OP_START = 2'd3
	} op_t;

	// Where the row bits of a column come from
	typedef enum logic [1:0] {
		SRC_BLANK = 2'd0,
		SRC_USER  = 2'd1,
		SRC_FONT  = 2'd2
	} src_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCROLL_RIGHT  = 3'd0,
		CFG_SCROLL_ENABLE = 3'd1,
		CFG_SCROLL_PERIOD = 3'd2,
		CFG_SENTENCE_LEN  = 3'd3,
		CFG_DISPLAY_OFF   = 3'd4,
		CFG_DEVICE_POS    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [6:0] address;
		logic [7:0] value;
	} in_t;

	typedef struct packed {
		logic [2:0]  scan_column;
		logic [1:0]  pattern_source;
		logic [7:0]  row_pattern;
		logic [10:0] font_address;
	} out_t;

endpackage

// ----- sv/scrolling_matrix_marquee.sv -----
// Scrolling LED matrix marquee: top level with scroll state and result pipeline.
// Depends on smm_pkg and smm_ram.
//
// Usage:
//  Input channel (in_valid/in_ready/in_data) carries one operation a beat:
//  tick, write sentence character, write user glyph byte, or return to start.
//  Only a tick taken while the display is on and the sentence length is
//  between 1 and MAX_SENTENCE-1 makes a result; other beats make none.
//  Output channel (out_valid/out_ready/out_data) carries the scanned column,
//  its pattern source, the user glyph row bits or the font ROM address.
//  Pipeline: a taken tick is registered in stage 1, where the sentence
//  RAM read lands, then in stage 2, where the user glyph RAM read lands;
//  its result is offered from stage 2.
//  Throughput: one beat a cycle while in_ready is high, any mix of operations.
//  Stall: a held result sits in the output stage while one more tick moves
//  into stage 1; in_ready drops only when both stages are full and blocked.
//  Configuration writes (cfg_wr_en/cfg_index/cfg_data) take effect at once
//  and are expected only while the block is idle.
//  Reset: registers return to their defaults, scroll state clears; the
//  sentence and glyph stores keep no reset and must be written before use.
module scrolling_matrix_marquee
	import smm_pkg::*;
#(
	parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LW = $clog2(MAX_SENTENCE);

	// Remainder by five of an 8-bit value, by shifted subtraction
	function automatic logic [2:0] mod5(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int k = 5; k >= 0; k--) begin
			if (r >= 8'(5 << k)) r = r - 8'(5 << k);
		end
		return 3'(r);
	endfunction

	// Remainder by the sentence depth of an 8-bit value
	function automatic logic [LW-1:0] mod_len(input logic [7:0] v);
		logic [8:0] r;
		r = 9'(v);
		for (int k = 7; k >= 0; k--) begin
			if ((MAX_SENTENCE << k) <= 255 && r >= 9'(MAX_SENTENCE << k)) begin
				r = r - 9'(MAX_SENTENCE << k);
			end
		end
		return LW'(r);
	endfunction

	// Configuration registers
	logic       right_q, enable_q, disp_off_q;
	logic [7:0] period_q, len_q, dev_pos_q;

	// Scroll state
	logic [2:0]    offset_q, scan_q;
	logic [LW-1:0] letter_q;
	logic [10:0]   timer_q;

	// Pipeline
	logic          valid_s1, valid_s2;
	logic [2:0]    scan_s1, col_s1;
	logic          blank_s1;
	logic [7:0]    code_s1;
	logic [2:0]    scan_s2;
	src_t          src_s2;
	logic [10:0]   font_s2;
	logic [7:0]    glyph_s2;

	logic          adv_s1, accept, tick_go, active, step;
	logic [8:0]    letter9, last9, next9, rd_idx9;
	logic [3:0]    sum;
	logic [2:0]    col;
	logic [10:0]   timer_inc;
	logic [2:0]    offset_d;
	logic [LW-1:0] letter_d;
	logic [7:0]    pos_delta;
	logic          char_we, glyph_we;
	logic [USER_AW-1:0] glyph_raddr;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q    <= 1'b0;
			enable_q   <= 1'b1;
			period_q   <= 8'd10;
			len_q      <= 8'd0;
			disp_off_q <= 1'b0;
			dev_pos_q  <= 8'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SCROLL_RIGHT:  right_q    <= cfg_data[0];
				CFG_SCROLL_ENABLE: enable_q   <= cfg_data[0];
				CFG_SCROLL_PERIOD: period_q   <= cfg_data;
				CFG_SENTENCE_LEN:  len_q      <= cfg_data;
				CFG_DISPLAY_OFF:   disp_off_q <= cfg_data[0];
				CFG_DEVICE_POS:    dev_pos_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake and beat decode
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;
	assign active   = !disp_off_q && (len_q != 8'd0)
		&& (9'(len_q) <= 9'(MAX_SENTENCE - 1));
	assign tick_go  = accept && (in_data.opcode == OP_TICK) && active;
	assign char_we  = accept && (in_data.opcode == OP_CHAR)
		&& (9'(in_data.address) < 9'(MAX_SENTENCE));
	assign glyph_we = accept && (in_data.opcode == OP_GLYPH)
		&& (in_data.address < 7'(USER_BYTES));

	// Pick the column shown and the letter it belongs to
	always_comb begin
		letter9 = 9'(letter_q);
		last9   = 9'(len_q) - 9'd1;
		if (letter9 == last9) begin
			next9 = 9'd0;
		end else if (letter9 < last9) begin
			next9 = letter9 + 9'd1;
		end else if (right_q) begin
			next9 = (letter9 == 9'(MAX_SENTENCE - 1)) ? 9'd0 : letter9 + 9'd1;
		end else begin
			next9 = 9'd0;
		end
		sum = 4'(offset_q) + 4'(scan_q);
		if (sum > 4'(GLYPH_COLUMNS)) begin
			rd_idx9 = next9;
			col     = 3'(sum - 4'(SPACED_COLUMNS));
		end else begin
			rd_idx9 = letter9;
			col     = 3'(sum);
		end
	end

	// Timer count and scroll step decision
	assign timer_inc = enable_q ? timer_q + 11'd1 : timer_q;
	assign step      = enable_q && (timer_inc == {period_q, 3'b000});
	assign pos_delta = dev_pos_q - 8'd2;

	// Next offset and letter for a scroll step or a return to start
	always_comb begin
		offset_d = offset_q;
		letter_d = letter_q;
		if (accept && in_data.opcode == OP_START) begin
			if (dev_pos_q == 8'd1) begin
				offset_d = 3'd0;
				letter_d = '0;
			end else if (dev_pos_q == 8'd2) begin
				offset_d = 3'(GLYPH_COLUMNS);
				letter_d = '0;
			end else if (dev_pos_q > 8'd2) begin
				offset_d = 3'(GLYPH_COLUMNS) - mod5(pos_delta);
				letter_d = mod_len(pos_delta);
			end
		end else if (tick_go && step) begin
			if (right_q) begin
				if (offset_q == 3'd0) begin
					offset_d = 3'(GLYPH_COLUMNS);
					letter_d = (letter_q == '0) ? LW'(last9) : letter_q - LW'(1);
				end else begin
					offset_d = offset_q - 3'd1;
				end
			end else if (offset_q == 3'(GLYPH_COLUMNS)) begin
				offset_d = 3'd0;
				letter_d = (letter9 + 9'd1 > last9) ? '0 : LW'(letter9 + 9'd1);
			end else begin
				offset_d = offset_q + 3'd1;
			end
		end
	end

	// Scroll state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			letter_q <= '0;
			scan_q   <= '0;
			timer_q  <= '0;
		end else begin
			offset_q <= offset_d;
			letter_q <= letter_d;
			if (tick_go) begin
				scan_q  <= (scan_q == 3'(GLYPH_COLUMNS - 1)) ? 3'd0 : scan_q + 3'd1;
				timer_q <= step ? 11'd0 : timer_inc;
			end
		end
	end

	// Sentence store: read the character for the shown column
	smm_ram #(.WIDTH(8), .DEPTH(MAX_SENTENCE), .AW(LW)) u_sentence (
		.clk   (clk),
		.we    (char_we),
		.waddr (LW'(in_data.address)),
		.wdata (in_data.value),
		.re    (tick_go),
		.raddr (LW'(rd_idx9)),
		.rdata (code_s1)
	);

	// Stage 1 control and column metadata
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			scan_s1  <= scan_q;
			col_s1   <= col;
			blank_s1 <= (sum == 4'(GLYPH_COLUMNS));
		end
	end

	// User glyph store: read the byte for a low character code
	assign glyph_raddr = USER_AW'(7'(code_s1[3:0]) * 7'd5 + 7'(col_s1));

	smm_ram #(.WIDTH(8), .DEPTH(USER_BYTES), .AW(USER_AW)) u_glyph (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (USER_AW'(in_data.address)),
		.wdata (in_data.value),
		.re    (adv_s1),
		.raddr (glyph_raddr),
		.rdata (glyph_s2)
	);

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			scan_s2 <= scan_s1;
			if (blank_s1) begin
				src_s2  <= SRC_BLANK;
				font_s2 <= '0;
			end else if (code_s1 < 8'(USER_CODES)) begin
				src_s2  <= SRC_USER;
				font_s2 <= '0;
			end else begin
				src_s2  <= SRC_FONT;
				font_s2 <= 11'(code_s1) * 11'd5 + 11'(col_s1);
			end
		end
	end

	// Drive the result beat
	assign out_valid                = valid_s2;
	assign out_data.scan_column     = scan_s2;
	assign out_data.pattern_source  = src_s2;
	assign out_data.row_pattern     = (src_s2 == SRC_USER) ? glyph_s2 : 8'd0;
	assign out_data.font_address    = font_s2;

	// Checks
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= 3'(GLYPH_COLUMNS))
		else $error("column offset out of range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q < 3'(GLYPH_COLUMNS))
		else $error("scan counter out of range");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.opcode == OP_TICK && !active
		|=> $stable(offset_q) && $stable(letter_q) && $stable(scan_q) && $stable(timer_q))
		else $error("inactive tick changed scroll state");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input blocked with stage 1 empty");

endmodule

// ----- sv/smm_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// Read data updates only when the read enable is high.
// No dependencies.
module smm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
